FILE: rtl/approx_log_multiplier_macros.svh
// Assertion macros shared by the approximate log multiplier RTL.
`ifndef APPROX_LOG_MULTIPLIER_MACROS_SVH
`define APPROX_LOG_MULTIPLIER_MACROS_SVH
`ifndef SYNTH
// Concurrent check, disabled while reset is asserted (active low).
`define ALM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent check that also holds through reset.
`define ALM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALM_ASSERT(lbl, clk, rstn, prop, msg)
`define ALM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/alm_pkg.sv
// Shared constants for the approximate log multiplier.
package alm_pkg;

    // Default operand width in bits
    localparam int C_WIDTH = 16;

endpackage

FILE: rtl/alm_ifs.sv
// Valid/ready channel interfaces: operand requests, results, configuration.

// Operand pair channel
interface alm_in_if #(
    parameter int WIDTH = alm_pkg::C_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] operand_a;
    logic [WIDTH-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

// Product channel
interface alm_out_if #(
    parameter int WIDTH = alm_pkg::C_WIDTH
);
    logic               valid;
    logic               ready;
    logic [2*WIDTH-1:0] product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

// Configuration write channel (single register)
interface alm_cfg_if;
    logic valid;
    logic ready;
    logic signed_mode;

    modport source (output valid, output signed_mode, input ready);
    modport sink   (input valid, input signed_mode, output ready);
endinterface

FILE: rtl/approx_log_multiplier.sv
// Top level of the approximate (Mitchell) log multiplier.
//
// Channels: i_op carries operand requests (operand_a, operand_b), o_res
// carries one product per request, i_cfg writes the signed_mode register.
// All use valid/ready; a transfer happens on a clock edge with both high.
// An accepted request loads the operand register; its product then loads the
// result register once that register can take it, and is then valid on o_res.
// Throughput: one request per cycle unless o_res stalls, set by the
// two-register pipeline; the datapath between them is a single pass
// with no iteration. When o_res is stalled the result register holds;
// the operand register still takes one more request, then i_op.ready
// drops until o_res drains. i_cfg.ready is always high; the user must
// see that signed_mode is written only while the pipeline is empty;
// the block itself does not enforce it. Reset (i_rst_n low, synchronous):
// both pipeline stages empty, signed_mode cleared to unsigned.
module approx_log_multiplier #(
    parameter int WIDTH = alm_pkg::C_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    alm_in_if.sink                i_op,
    alm_cfg_if.sink               i_cfg,
    alm_out_if.source             o_res
);

`include "approx_log_multiplier_macros.svh"

    localparam int PW = 2 * WIDTH;

    logic             r_signed_mode;
    logic             r_s1_valid, n_s1_valid;
    logic [WIDTH-1:0] r_a, r_b;
    logic             r_out_valid, n_out_valid;
    logic [PW-1:0]    r_res;
    logic [PW-1:0]    core_product;
    logic             s1_ready, s2_ready, s1_fire;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            r_signed_mode <= i_cfg.signed_mode;
        end
    end

    // Pipeline flow control
    assign s2_ready   = !r_out_valid || o_res.ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign s1_fire    = r_s1_valid && s2_ready;
    assign i_op.ready = s1_ready;

    assign n_s1_valid  = s1_ready ? i_op.valid : r_s1_valid;
    assign n_out_valid = s2_ready ? r_s1_valid : r_out_valid;

    // Operand register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.valid && s1_ready) begin
            r_a <= i_op.operand_a;
            r_b <= i_op.operand_b;
        end
    end

    // Datapath
    alm_core #(.WIDTH(WIDTH)) u_core (
        .i_a           (r_a),
        .i_b           (r_b),
        .i_signed_mode (r_signed_mode),
        .o_product     (core_product)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_res <= core_product;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.product = r_res;

    // Checks
    `ALM_ASSERT(a_stage_advance, i_clk, i_rst_n, s1_fire |=> r_out_valid, "advanced request lost")
    `ALM_ASSERT(a_full_backpressure, i_clk, i_rst_n, (r_s1_valid && r_out_valid && !o_res.ready) |-> !i_op.ready, "accepted request while pipeline full")
    `ALM_ASSERT(a_zero_operand, i_clk, i_rst_n, (s1_fire && ((r_a == '0) || (r_b == '0))) |=> (r_res == '0), "zero operand gave nonzero product")
    `ALM_ASSERT(a_unsigned_one, i_clk, i_rst_n, (s1_fire && !r_signed_mode && (r_a == WIDTH'(1))) |=> (r_res == PW'($past(r_b))), "unsigned times one not exact")
    `ALM_ASSERT_ALWAYS(a_reset_empty, i_clk, !$past(i_rst_n) |-> (!r_s1_valid && !r_out_valid), "pipeline not empty after reset")

endmodule

FILE: rtl/alm_lod.sv
// Leading-one detector: position of the highest set bit of a word.
module alm_lod #(
    parameter int WIDTH = alm_pkg::C_WIDTH
) (
    input  logic [WIDTH-1:0]         i_value,
    output logic [$clog2(WIDTH)-1:0] o_pos
);

    localparam int KW = $clog2(WIDTH);

    // Priority encode, highest bit wins; zero input gives position 0
    always_comb begin
        o_pos = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (i_value[i]) begin
                o_pos = KW'(i);
            end
        end
    end

endmodule

FILE: rtl/alm_core.sv
// Mitchell log-domain product datapath with sign handling and special cases.
module alm_core #(
    parameter int WIDTH = alm_pkg::C_WIDTH
) (
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    input  logic               i_signed_mode,
    output logic [2*WIDTH-1:0] o_product
);

    localparam int KW  = $clog2(WIDTH);
    localparam int SW  = $clog2(WIDTH + 1);
    localparam int KKW = $clog2(2 * WIDTH);
    localparam int PW  = 2 * WIDTH;
    localparam int XW  = 3 * WIDTH;
    localparam logic [SW-1:0]    C_WS  = SW'(WIDTH);
    localparam logic [WIDTH-1:0] C_ONE = WIDTH'(1);

    logic             sign_a, sign_b;
    logic [WIDTH-1:0] mag_a, mag_b;
    logic [KW-1:0]    k_a, k_b;
    logic [WIDTH-1:0] clr_a, clr_b;
    logic [SW-1:0]    sh_a, sh_b;
    logic [PW-1:0]    fx_a, fx_b;
    logic [WIDTH-1:0] frac_a, frac_b;
    logic [WIDTH:0]   frac_sum;
    logic [WIDTH:0]   mant;
    logic [KKW-1:0]   kk;
    logic [XW-1:0]    mant_sh;
    logic [PW-1:0]    mitch;
    logic             any_zero;

    // Signs and magnitudes (most negative value maps to 2^(WIDTH-1))
    assign sign_a = i_signed_mode & i_a[WIDTH-1];
    assign sign_b = i_signed_mode & i_b[WIDTH-1];
    assign mag_a  = sign_a ? (~i_a + C_ONE) : i_a;
    assign mag_b  = sign_b ? (~i_b + C_ONE) : i_b;

    // Characteristics
    alm_lod #(.WIDTH(WIDTH)) u_lod_a (.i_value(mag_a), .o_pos(k_a));
    alm_lod #(.WIDTH(WIDTH)) u_lod_b (.i_value(mag_b), .o_pos(k_b));

    // Fractions aligned to WIDTH fraction bits
    assign clr_a  = mag_a & ~(C_ONE << k_a);
    assign clr_b  = mag_b & ~(C_ONE << k_b);
    assign sh_a   = C_WS - SW'(k_a);
    assign sh_b   = C_WS - SW'(k_b);
    assign fx_a   = {{WIDTH{1'b0}}, clr_a} << sh_a;
    assign fx_b   = {{WIDTH{1'b0}}, clr_b} << sh_b;
    assign frac_a = fx_a[WIDTH-1:0];
    assign frac_b = fx_b[WIDTH-1:0];

    // Fraction sum; on carry the implicit one is dropped and the exponent bumps
    assign frac_sum = {1'b0, frac_a} + {1'b0, frac_b};
    assign mant     = frac_sum[WIDTH] ? frac_sum : {1'b1, frac_sum[WIDTH-1:0]};
    assign kk       = KKW'(k_a) + KKW'(k_b) + KKW'(frac_sum[WIDTH]);

    // Antilog: scale by 2^kk, drop the WIDTH fraction bits
    assign mant_sh = {{(XW-WIDTH-1){1'b0}}, mant} << kk;
    assign mitch   = mant_sh[XW-1:WIDTH];

    assign any_zero = (i_a == '0) || (i_b == '0);

    // Result selection
    always_comb begin
        if (i_signed_mode && (i_a == C_ONE)) begin
            o_product = {{WIDTH{i_b[WIDTH-1]}}, i_b};
        end else if (i_signed_mode && (i_b == C_ONE)) begin
            o_product = {{WIDTH{i_a[WIDTH-1]}}, i_a};
        end else if (any_zero) begin
            o_product = '0;
        end else if (sign_a ^ sign_b) begin
            o_product = ~mitch + PW'(1);
        end else begin
            o_product = mitch;
        end
    end

endmodule
